/* rtl/core/mdv_pkg.sv */
// shared types, constants and sine table builder for the vibrato delay block
package mdv_pkg;

    localparam int unsigned DELAY_DEPTH_DEF     = 65536;
    localparam int unsigned SINE_TABLE_SIZE_DEF = 1024;

    localparam int unsigned AUDIO_W  = 24;
    localparam int unsigned OFFSET_W = 24;
    localparam int unsigned DEPTH_W  = 16;
    localparam int unsigned STEP_W   = 24;
    localparam int unsigned BLEND_W  = 15;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned PHASE_W  = 32;
    localparam int unsigned SINE_W   = 16;
    localparam int unsigned FRAC_W   = 8;

    localparam logic [CFG_IDX_W-1:0] REG_VIB_DEPTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRY_BLEND  = 2'd2;

    localparam logic [DEPTH_W-1:0] VIB_DEPTH_RST  = 16'd256;
    localparam logic [STEP_W-1:0]  PHASE_STEP_RST = 24'd97391;
    localparam logic [BLEND_W-1:0] DRY_BLEND_RST  = 15'd16384;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef struct packed {
        logic [DEPTH_W-1:0] vib_depth;
        logic [STEP_W-1:0]  phase_step;
        logic [BLEND_W-1:0] dry_blend;
    } cfg_t;

    // sin(n/size * pi/2) in q1.15, taylor series to the 15th power in q2.30
    function automatic logic [SINE_W-1:0] quarter_sine(int unsigned n, int unsigned aw);
        logic [63:0] theta;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        theta = (64'(n) * HALF_PI_Q30) >> aw;
        x2    = (theta * theta) >> 30;
        sum   = theta;
        term  = ((theta * x2) >> 30) / 64'd6;
        sum   = (sum >= term) ? sum - term : 64'd0;
        term  = ((term * x2) >> 30) / 64'd20;
        sum   = sum + term;
        term  = ((term * x2) >> 30) / 64'd42;
        sum   = (sum >= term) ? sum - term : 64'd0;
        term  = ((term * x2) >> 30) / 64'd72;
        sum   = sum + term;
        term  = ((term * x2) >> 30) / 64'd110;
        sum   = (sum >= term) ? sum - term : 64'd0;
        term  = ((term * x2) >> 30) / 64'd156;
        sum   = sum + term;
        term  = ((term * x2) >> 30) / 64'd210;
        sum   = (sum >= term) ? sum - term : 64'd0;
        sum   = (sum + 64'd16384) >> 15;
        if (sum > 64'd32767)
        begin
            sum = 64'd32767;
        end
        return SINE_W'(sum);
    endfunction

    // full-wave table entry i for a table of 2^aw entries
    function automatic logic signed [SINE_W-1:0] sine_entry(int unsigned i, int unsigned aw);
        int unsigned pos;
        int unsigned quad;
        int unsigned rem;
        int unsigned size;
        logic [SINE_W-1:0] q;
        size = 1 << aw;
        pos  = 4 * i;
        quad = (pos >> aw) & 3;
        rem  = pos & (size - 1);
        case (quad)
            0: q = quarter_sine(rem, aw);
            1: q = quarter_sine(size - rem, aw);
            2: q = -quarter_sine(rem, aw);
            default: q = -quarter_sine(size - rem, aw);
        endcase
        return $signed(q);
    endfunction

endpackage

/* rtl/core/mdv_front.sv */
// front end: takes input beats, runs the sine lfo and works out the tap delay
module mdv_front #(
    parameter int unsigned DELAY_DEPTH     = mdv_pkg::DELAY_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_SIZE = mdv_pkg::SINE_TABLE_SIZE_DEF,
    localparam int unsigned DAW = $clog2(DELAY_DEPTH),
    localparam int unsigned QW  = mdv_pkg::AUDIO_W + mdv_pkg::FRAC_W + DAW
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mdv_pkg::cfg_t                 cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [mdv_pkg::AUDIO_W-1:0]   in_audio,
    input  logic [mdv_pkg::OFFSET_W-1:0]  in_offset,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [QW-1:0]                 q_data
);

    localparam int unsigned SAW = $clog2(SINE_TABLE_SIZE);
    localparam int unsigned SUM_W = mdv_pkg::OFFSET_W + 1;
    localparam int unsigned CW = (DAW + mdv_pkg::FRAC_W > SUM_W) ?
                                 DAW + mdv_pkg::FRAC_W : SUM_W;
    localparam logic [CW-1:0] MAXD = CW'(DELAY_DEPTH - 2) << mdv_pkg::FRAC_W;

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_MOD  = 2'd1;
    localparam logic [1:0] F_DLY  = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic [mdv_pkg::PHASE_W-1:0]         phase_reg;
    logic [mdv_pkg::AUDIO_W-1:0]         x_reg;
    logic [mdv_pkg::OFFSET_W-1:0]        off_reg;
    logic [mdv_pkg::DEPTH_W-1:0]         mod_reg;
    logic signed [mdv_pkg::SINE_W-1:0]   sine_q_reg;
    logic signed [mdv_pkg::SINE_W-1:0]   sine_rom [SINE_TABLE_SIZE];
    logic [mdv_pkg::SINE_W:0]            bias;
    logic [2*mdv_pkg::SINE_W:0]          mod_prod;
    logic [CW-1:0]                       dly_sum;
    logic [CW-1:0]                       dly_clamp;
    logic                                push;

    for (genvar g = 0; g < SINE_TABLE_SIZE; g++)
    begin : g_rom
        assign sine_rom[g] = mdv_pkg::sine_entry(g, SAW);
    end

    // table address follows the phase register, read data arrives in the next cycle
    always_ff @(posedge clk)
    begin
        sine_q_reg <= sine_rom[phase_reg[mdv_pkg::PHASE_W-1 -: SAW]];
    end

    // 32768 + sin stays within 1..65535
    assign bias     = 17'h08000 + {sine_q_reg[mdv_pkg::SINE_W-1], sine_q_reg};
    assign mod_prod = 33'(cfg.vib_depth) * 33'(bias);

    assign dly_sum   = CW'(mod_reg) + CW'(off_reg);
    assign dly_clamp = (dly_sum > MAXD) ? MAXD : dly_sum;

    assign in_ready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_DLY);
    assign q_data   = {dly_clamp[DAW+mdv_pkg::FRAC_W-1:mdv_pkg::FRAC_W],
                       dly_clamp[mdv_pkg::FRAC_W-1:0], x_reg};
    assign push     = q_valid && q_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MOD;
                end
            end
            F_MOD:
            begin
                state_next = F_DLY;
            end
            F_DLY:
            begin
                if (q_ready)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
            begin
                phase_reg <= phase_reg + mdv_pkg::PHASE_W'(cfg.phase_step);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            x_reg   <= in_audio;
            off_reg <= in_offset;
        end
        if (state_reg == F_MOD)
        begin
            mod_reg <= mod_prod[31:16];
        end
    end

endmodule

/* rtl/core/mdv_queue.sv */
// two-entry queue between the front end and the back end
module mdv_queue #(
    parameter int unsigned WIDTH = 40
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);

    logic [WIDTH-1:0] entry_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/core/mdv_back.sv */
// back end: delay memory, tap reads, interpolation, dry blend and output register
module mdv_back #(
    parameter int unsigned DELAY_DEPTH = mdv_pkg::DELAY_DEPTH_DEF,
    localparam int unsigned DAW = $clog2(DELAY_DEPTH),
    localparam int unsigned QW  = mdv_pkg::AUDIO_W + mdv_pkg::FRAC_W + DAW
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [mdv_pkg::BLEND_W-1:0]  dry_blend,
    input  logic                         q_valid,
    output logic                         q_ready,
    input  logic [QW-1:0]                q_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mdv_pkg::AUDIO_W-1:0]  out_data
);

    localparam int unsigned FW = $clog2(DELAY_DEPTH + 1);
    localparam int unsigned AW = mdv_pkg::AUDIO_W;

    localparam logic [2:0] B_IDLE = 3'd0;
    localparam logic [2:0] B_RDA  = 3'd1;
    localparam logic [2:0] B_RDB  = 3'd2;
    localparam logic [2:0] B_MULB = 3'd3;
    localparam logic [2:0] B_SUM  = 3'd4;
    localparam logic [2:0] B_OUT  = 3'd5;

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic [DAW-1:0]            wp_reg;
    logic [FW-1:0]             fill_reg;
    logic [DAW-1:0]            k_reg;
    logic [7:0]                f_reg;
    logic signed [39:0]        dry_reg;
    logic                      a_ok_reg;
    logic                      b_ok_reg;
    logic signed [33:0]        pa_reg;
    logic signed [33:0]        pb_reg;
    logic signed [34:0]        sab_reg;
    logic signed [AW-1:0]      rd_q_reg;
    logic                      out_valid_reg;
    logic [AW-1:0]             out_data_reg;
    logic [AW-1:0]             mem [DELAY_DEPTH];

    logic signed [AW-1:0]      q_x;
    logic [7:0]                q_f;
    logic [DAW-1:0]            q_k;
    logic                      take;
    logic                      mem_re;
    logic [DAW:0]              diff_a;
    logic [DAW:0]              diff_b;
    logic [DAW-1:0]            ia;
    logic [DAW-1:0]            ib;
    logic [DAW-1:0]            rd_addr;
    logic signed [AW-1:0]      tap_a;
    logic signed [AW-1:0]      tap_b;
    logic [8:0]                w_a;
    logic signed [40:0]        acc;
    logic signed [40:0]        rnd;
    logic signed [26:0]        y;
    logic [AW-1:0]             y_sat;
    logic                      load_out;

    assign q_x = q_data[AW-1:0];
    assign q_f = q_data[AW+7:AW];
    assign q_k = q_data[QW-1:AW+8];

    assign q_ready = (state_reg == B_IDLE);
    assign take    = q_valid && q_ready;

    // circular addressing, wrapping by adding the depth back in
    assign diff_a = {1'b0, wp_reg} - {1'b0, k_reg};
    assign diff_b = {1'b0, wp_reg} - {1'b0, k_reg} - (DAW+1)'(1);
    assign ia = diff_a[DAW] ? DAW'(diff_a + (DAW+1)'(DELAY_DEPTH)) : diff_a[DAW-1:0];
    assign ib = diff_b[DAW] ? DAW'(diff_b + (DAW+1)'(DELAY_DEPTH)) : diff_b[DAW-1:0];
    assign rd_addr = (state_reg == B_RDA) ? ia : ib;
    assign mem_re  = (state_reg == B_RDA) || (state_reg == B_RDB);

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mem[wp_reg] <= q_x;
        end
        if (mem_re)
        begin
            rd_q_reg <= mem[rd_addr];
        end
    end

    // entries not yet written since reset read as silence
    assign tap_a = a_ok_reg ? rd_q_reg : 24'sd0;
    assign tap_b = b_ok_reg ? rd_q_reg : 24'sd0;
    assign w_a   = 9'd256 - {1'b0, f_reg};

    assign acc = $signed({sab_reg, 6'b0}) + 41'(dry_reg);
    assign rnd = acc + 41'sd8192;
    assign y   = rnd[40:14];

    always_comb
    begin
        if (y > 27'sd8388607)
        begin
            y_sat = 24'h7FFFFF;
        end
        else if (y < -27'sd8388608)
        begin
            y_sat = 24'h800000;
        end
        else
        begin
            y_sat = y[AW-1:0];
        end
    end

    assign load_out  = (state_reg == B_OUT) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = B_RDA;
                end
            end
            B_RDA:  state_next = B_RDB;
            B_RDB:  state_next = B_MULB;
            B_MULB: state_next = B_SUM;
            B_SUM:  state_next = B_OUT;
            B_OUT:
            begin
                if (load_out)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take && (fill_reg != FW'(DELAY_DEPTH)))
            begin
                fill_reg <= fill_reg + FW'(1);
            end
            if (load_out)
            begin
                wp_reg <= (wp_reg == DAW'(DELAY_DEPTH - 1)) ? '0 : wp_reg + DAW'(1);
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            k_reg   <= q_k;
            f_reg   <= q_f;
            dry_reg <= 40'($signed({1'b0, dry_blend})) * 40'(q_x);
        end
        if (state_reg == B_RDA)
        begin
            a_ok_reg <= FW'(k_reg) < fill_reg;
            b_ok_reg <= (FW'(k_reg) + FW'(1)) < fill_reg;
        end
        if (state_reg == B_RDB)
        begin
            pa_reg <= 34'($signed({1'b0, w_a})) * 34'(tap_a);
        end
        if (state_reg == B_MULB)
        begin
            pb_reg <= 34'($signed({1'b0, f_reg})) * 34'(tap_b);
        end
        if (state_reg == B_SUM)
        begin
            sab_reg <= 35'(pa_reg) + 35'(pb_reg);
        end
        if (load_out)
        begin
            out_data_reg <= y_sat;
        end
    end

endmodule

/* rtl/core/modulated_delay_vibrato.sv */
// Vibrato by a sine-modulated delay line with linear interpolation between two taps.
// Each input beat carries a q1.23 sample and a q16.8 extra delay; each gives exactly
// one output beat, in order. The front end works on one beat at a time (sine table
// read, depth multiply, delay add and clamp) and hands it on through a two-entry
// queue; the back end's sequencer works on one sample at a time: write to the
// delay memory, two tap reads through its single read port, two tap multiplies, the
// sum, then rounding and saturation into the output register. The back end takes a
// new sample only once the last one is loaded into the output register. The delay
// memory is not cleared: a fill count makes taps older than the samples written
// since reset read as zero, so no clearing pass is needed. Register writes take
// effect at once and are meant for when the block is idle.
module modulated_delay_vibrato #(
    parameter int unsigned DELAY_DEPTH     = mdv_pkg::DELAY_DEPTH_DEF,
    parameter int unsigned SINE_TABLE_SIZE = mdv_pkg::SINE_TABLE_SIZE_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [47:0]                    s_tdata,   // audio_in [23:0], delay_offset [47:24]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [23:0]                    m_tdata,   // audio_out [23:0]
    input  logic                           cfg_we,
    input  logic [mdv_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mdv_pkg::CFG_W-1:0]      cfg_wdata
);

    localparam int unsigned DAW = $clog2(DELAY_DEPTH);
    localparam int unsigned QW  = mdv_pkg::AUDIO_W + mdv_pkg::FRAC_W + DAW;

    mdv_pkg::cfg_t  cfg_reg;
    logic           q_in_valid;
    logic           q_in_ready;
    logic [QW-1:0]  q_in_data;
    logic           q_out_valid;
    logic           q_out_ready;
    logic [QW-1:0]  q_out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.vib_depth  <= mdv_pkg::VIB_DEPTH_RST;
            cfg_reg.phase_step <= mdv_pkg::PHASE_STEP_RST;
            cfg_reg.dry_blend  <= mdv_pkg::DRY_BLEND_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                mdv_pkg::REG_VIB_DEPTH:  cfg_reg.vib_depth  <= cfg_wdata[mdv_pkg::DEPTH_W-1:0];
                mdv_pkg::REG_PHASE_STEP: cfg_reg.phase_step <= cfg_wdata[mdv_pkg::STEP_W-1:0];
                mdv_pkg::REG_DRY_BLEND:  cfg_reg.dry_blend  <= cfg_wdata[mdv_pkg::BLEND_W-1:0];
                default:
                begin
                    // unknown index: ignored
                end
            endcase
        end
    end

    mdv_front #(
        .DELAY_DEPTH     (DELAY_DEPTH),
        .SINE_TABLE_SIZE (SINE_TABLE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_audio  (s_tdata[23:0]),
        .in_offset (s_tdata[47:24]),
        .q_valid   (q_in_valid),
        .q_ready   (q_in_ready),
        .q_data    (q_in_data)
    );

    mdv_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (q_in_valid),
        .push_ready (q_in_ready),
        .push_data  (q_in_data),
        .pop_valid  (q_out_valid),
        .pop_ready  (q_out_ready),
        .pop_data   (q_out_data)
    );

    mdv_back #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .dry_blend (cfg_reg.dry_blend),
        .q_valid   (q_out_valid),
        .q_ready   (q_out_ready),
        .q_data    (q_out_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule
